FILE: rtl/quadratic_real_roots_assert.svh
// ----------------------------------------------------------------------------
// quadratic_real_roots_assert.svh
// Assertion macros for the quadratic root solver, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_REAL_ROOTS_ASSERT_SVH
`define QUADRATIC_REAL_ROOTS_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define QRR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define QRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QRR_ASSERT_IMPL(lbl, ante, cons, msg)
`define QRR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg
// Widths, status codes and stage sideband type of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrr_pkg;

  localparam int CoefW = 16;
  localparam int FracB = 16;
  // Discriminant magnitude, signed discriminant.
  localparam int RadW  = 2 * CoefW + 1;
  localparam int DiscW = RadW + 2;
  // Radicand is d * 2^(2F+2), padded to an even number of bits.
  localparam int ShW   = 2 * FracB + 2;
  localparam int SqrtN = (RadW + ShW + 1) / 2;
  localparam int PadW  = 2 * SqrtN;
  localparam int RemW  = SqrtN + 2;
  localparam int XW    = CoefW + FracB + 3;
  localparam int ZW    = XW + 2;
  localparam int MW    = CoefW + 2;
  localparam int NW    = ZW;
  localparam int RootW = 33;

  localparam logic signed [NW:0] RootMax = (NW+1)'(64'sd4294967295);
  localparam logic signed [NW:0] RootMin = -(NW+1)'(64'sd4294967296);

  typedef enum logic [1:0] {
    StTwo    = 2'd0,
    StRepeat = 2'd1,
    StNone   = 2'd2,
    StZeroA  = 2'd3
  } status_e;

  typedef struct packed {
    status_e               status;
    logic                  a_neg;
    logic signed [XW-1:0]  x;
    logic [MW-1:0]         m;
  } side_t;

endpackage

FILE: rtl/qrr_if.sv
// ----------------------------------------------------------------------------
// qrr_if
// Valid/ready channels: coefficient requests in, root results out.
// ----------------------------------------------------------------------------
interface qrr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [qrr_pkg::CoefW-1:0]   coef_quad;
  logic signed [qrr_pkg::CoefW-1:0]   coef_lin;
  logic signed [qrr_pkg::CoefW-1:0]   coef_const;
  modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
  modport sink   (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

interface qrr_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         root_status;
  logic signed [qrr_pkg::RootW-1:0]   root_plus;
  logic signed [qrr_pkg::RootW-1:0]   root_minus;
  modport source (output valid, root_status, root_plus, root_minus, input ready);
  modport sink   (input valid, root_status, root_plus, root_minus, output ready);
endinterface

FILE: rtl/qrr_disc.sv
// ----------------------------------------------------------------------------
// qrr_disc
// Two stages: products, then discriminant, status, scaled -b plus 2a and 4|a|.
// ----------------------------------------------------------------------------
module qrr_disc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [qrr_pkg::CoefW-1:0] a_i,
  input  logic signed [qrr_pkg::CoefW-1:0] b_i,
  input  logic signed [qrr_pkg::CoefW-1:0] c_i,
  output logic                             valid_o,
  output logic [qrr_pkg::RadW-1:0]         rad_o,
  output qrr_pkg::side_t                   side_o
);
  import qrr_pkg::*;

  logic                     v1_q, v2_q;
  logic signed [2*CoefW-1:0] bb_q, ac_q, bb_d, ac_d;
  logic signed [CoefW-1:0]  a_q, b_q;
  logic signed [DiscW-1:0]  disc;
  logic [CoefW:0]           amag;
  logic [RadW-1:0]          rad_d, rad_q;
  side_t                    side_d, side_q;

  assign bb_d = b_i * b_i;
  assign ac_d = a_i * c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q   <= bb_d;
      ac_q   <= ac_d;
      a_q    <= a_i;
      b_q    <= b_i;
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  always_comb begin
    disc = DiscW'(bb_q) - (DiscW'(ac_q) <<< 2);
    amag = a_q[CoefW-1] ? -(CoefW+1)'(a_q) : (CoefW+1)'(a_q);
    rad_d = disc[RadW-1:0];
    side_d.a_neg = a_q[CoefW-1];
    side_d.x = (XW'(a_q) <<< 1) - (XW'(b_q) <<< (FracB + 1));
    side_d.m = MW'({amag, 2'b00});
    if (a_q == '0) begin
      side_d.status = StZeroA;
    end else if (disc[DiscW-1]) begin
      side_d.status = StNone;
    end else if (disc == '0) begin
      side_d.status = StRepeat;
    end else begin
      side_d.status = StTwo;
    end
  end

  assign valid_o = v2_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/qrr_sqrt.sv
// ----------------------------------------------------------------------------
// qrr_sqrt
// Pipelined restoring square root, one result bit per stage, of d * 2^(2F+2).
// ----------------------------------------------------------------------------
module qrr_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qrr_pkg::RadW-1:0]   rad_i,
  input  qrr_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [qrr_pkg::SqrtN-1:0]  root_o,
  output logic                       inexact_o,
  output qrr_pkg::side_t             side_o
);
  import qrr_pkg::*;

  logic [SqrtN-1:0]  v_q;
  logic [PadW-1:0]   rad_q  [SqrtN];
  logic [RemW-1:0]   rem_q  [SqrtN];
  logic [SqrtN-1:0]  root_q [SqrtN];
  side_t             side_q [SqrtN];

  for (genvar i = 0; i < SqrtN; i++) begin : g_stage
    logic [PadW-1:0]   cur_rad;
    logic [RemW-1:0]   cur_rem;
    logic [SqrtN-1:0]  cur_root;
    side_t             cur_side;
    logic              cur_v;
    logic [RemW+1:0]   tmp, trial;
    logic [PadW-1:0]   rad_d;
    logic [RemW-1:0]   rem_d;
    logic [SqrtN-1:0]  root_d;

    if (i == 0) begin : g_first
      assign cur_rad  = PadW'({rad_i, {ShW{1'b0}}});
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = side_i;
      assign cur_v    = valid_i;
    end else begin : g_next
      assign cur_rad  = rad_q[i-1];
      assign cur_rem  = rem_q[i-1];
      assign cur_root = root_q[i-1];
      assign cur_side = side_q[i-1];
      assign cur_v    = v_q[i-1];
    end

    always_comb begin
      tmp   = {cur_rem, cur_rad[PadW-1 -: 2]};
      trial = (RemW+2)'({cur_root, 2'b01});
      rad_d = cur_rad << 2;
      if (tmp >= trial) begin
        rem_d  = RemW'(tmp - trial);
        root_d = {cur_root[SqrtN-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(tmp);
        root_d = {cur_root[SqrtN-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= rad_d;
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        side_q[i] <= cur_side;
      end
    end
  end

  assign valid_o   = v_q[SqrtN-1];
  assign root_o    = root_q[SqrtN-1];
  assign inexact_o = |rem_q[SqrtN-1];
  assign side_o    = side_q[SqrtN-1];

endmodule

FILE: rtl/qrr_div.sv
// ----------------------------------------------------------------------------
// qrr_div
// Forms both numerators, then divides them by 4|a| with floor rounding in
// two lanes of a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qrr_pkg::SqrtN-1:0]  root_i,
  input  logic                       inexact_i,
  input  qrr_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [qrr_pkg::NW-1:0]     quot_plus_o,
  output logic [qrr_pkg::NW-1:0]     quot_minus_o,
  output logic [1:0]                 neg_o,
  output qrr_pkg::side_t             side_o
);
  import qrr_pkg::*;

  // Numerator preparation, three stages.
  logic [2:0]              pv_q;
  logic [SqrtN-1:0]        s1_q;
  logic [SqrtN:0]          sceil_q;
  logic signed [XW-1:0]    xs_q;
  logic signed [ZW-1:0]    zp_q, zm_q, zp_d, zm_d, sz, ce, xz;
  logic [1:0]              neg_q;
  logic [NW-1:0]           n_q [2];
  logic [NW-1:0]           n_d [2];
  side_t                   ps_q [3];

  always_comb begin
    sz = $signed(ZW'(s1_q));
    ce = $signed(ZW'(sceil_q));
    xz = ZW'(xs_q);
    zp_d = ps_q[0].a_neg ? xz - ce : xz + sz;
    zm_d = ps_q[0].a_neg ? xz + sz : xz - ce;
    // Floor division of a negative numerator: -ceil(|z| / m).
    n_d[0] = zp_q[ZW-1] ? NW'(-zp_q) + NW'(ps_q[1].m) - NW'(1) : NW'(zp_q);
    n_d[1] = zm_q[ZW-1] ? NW'(-zm_q) + NW'(ps_q[1].m) - NW'(1) : NW'(zm_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en_i) begin
      pv_q <= {pv_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= root_i;
      sceil_q <= (SqrtN+1)'(root_i) + (SqrtN+1)'(inexact_i);
      xs_q    <= side_i.a_neg ? -side_i.x : side_i.x;
      ps_q[0] <= side_i;
      zp_q    <= zp_d;
      zm_q    <= zm_d;
      ps_q[1] <= ps_q[0];
      n_q[0]  <= n_d[0];
      n_q[1]  <= n_d[1];
      neg_q   <= {zm_q[ZW-1], zp_q[ZW-1]};
      ps_q[2] <= ps_q[1];
    end
  end

  // Divider stages.
  logic [NW-1:0]   v_q;
  logic [NW-1:0]   nq_q  [2][NW];
  logic [MW-1:0]   r_q   [2][NW];
  logic [1:0]      dneg_q [NW];
  side_t           ds_q  [NW];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic        cur_v;
    logic [1:0]  cur_neg;
    side_t       cur_side;

    if (j == 0) begin : g_first
      assign cur_v    = pv_q[2];
      assign cur_neg  = neg_q;
      assign cur_side = ps_q[2];
    end else begin : g_next
      assign cur_v    = v_q[j-1];
      assign cur_neg  = dneg_q[j-1];
      assign cur_side = ds_q[j-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NW-1:0]  cur_nq, nq_d;
      logic [MW-1:0]  cur_r, r_d;
      logic [MW:0]    tmp;

      if (j == 0) begin : g_first
        assign cur_nq = n_q[l];
        assign cur_r  = '0;
      end else begin : g_next
        assign cur_nq = nq_q[l][j-1];
        assign cur_r  = r_q[l][j-1];
      end

      always_comb begin
        tmp = {cur_r, cur_nq[NW-1]};
        if (tmp >= {1'b0, cur_side.m}) begin
          r_d  = MW'(tmp - {1'b0, cur_side.m});
          nq_d = {cur_nq[NW-2:0], 1'b1};
        end else begin
          r_d  = MW'(tmp);
          nq_d = {cur_nq[NW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nq_q[l][j] <= nq_d;
          r_q[l][j]  <= r_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dneg_q[j] <= cur_neg;
        ds_q[j]   <= cur_side;
      end
    end
  end

  assign valid_o      = v_q[NW-1];
  assign quot_plus_o  = nq_q[0][NW-1];
  assign quot_minus_o = nq_q[1][NW-1];
  assign neg_o        = dneg_q[NW-1];
  assign side_o       = ds_q[NW-1];

endmodule

FILE: rtl/quadratic_real_roots.sv
// ----------------------------------------------------------------------------
// quadratic_real_roots
// Real roots of a*x^2 + b*x + c in signed fixed point with 16 fraction bits.
// ----------------------------------------------------------------------------
// Usage: coefficient requests arrive on coef_i (coef_quad, coef_lin,
// coef_const, signed 16 bit); one result per request leaves on root_o with
// root_status and both roots (33 bit signed, rounded to nearest, saturated).
// Roots read zero when there are no real roots or the leading coefficient
// is zero.
// Stages from acceptance to a valid result: two discriminant
// stages, 34 square root stages (one root bit each), three numerator stages,
// 37 divider stages (one quotient bit each) and the output register.
// One request per cycle unless root_o stalls; the pipeline has no feedback.
// Reset clears every stage valid bit, so the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and coef_i.ready drops; nothing is lost or repeated. While the output
// register is empty, requests are taken even if root_o.ready is low.
// ----------------------------------------------------------------------------
`include "quadratic_real_roots_assert.svh"

module quadratic_real_roots (
  input  logic      clk_i,
  input  logic      rst_ni,
  qrr_in_if.sink    coef_i,
  qrr_out_if.source root_o
);
  import qrr_pkg::*;

  logic               en;
  logic               dv, sv, qv;
  logic [RadW-1:0]    rad;
  side_t              dside, sside, qside;
  logic [SqrtN-1:0]   sroot;
  logic               sinex;
  logic [NW-1:0]      qp, qm;
  logic [1:0]         qneg;
  logic signed [NW:0] vp, vm;
  logic signed [RootW-1:0] rp_d, rm_d, rp_q, rm_q;
  logic               out_v_q;
  status_e            st_q;

  assign en           = !out_v_q || root_o.ready;
  assign coef_i.ready = en;

  qrr_disc u_disc (
    .clk_i, .rst_ni, .en_i(en), .valid_i(coef_i.valid),
    .a_i(coef_i.coef_quad), .b_i(coef_i.coef_lin), .c_i(coef_i.coef_const),
    .valid_o(dv), .rad_o(rad), .side_o(dside)
  );

  qrr_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv), .rad_i(rad), .side_i(dside),
    .valid_o(sv), .root_o(sroot), .inexact_o(sinex), .side_o(sside)
  );

  qrr_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv), .root_i(sroot),
    .inexact_i(sinex), .side_i(sside), .valid_o(qv), .quot_plus_o(qp),
    .quot_minus_o(qm), .neg_o(qneg), .side_o(qside)
  );

  always_comb begin
    vp = qneg[0] ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
    vm = qneg[1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    if (vp > RootMax) begin
      rp_d = RootW'(RootMax);
    end else if (vp < RootMin) begin
      rp_d = RootW'(RootMin);
    end else begin
      rp_d = RootW'(vp);
    end
    if (vm > RootMax) begin
      rm_d = RootW'(RootMax);
    end else if (vm < RootMin) begin
      rm_d = RootW'(RootMin);
    end else begin
      rm_d = RootW'(vm);
    end
    if (qside.status == StNone || qside.status == StZeroA) begin
      rp_d = '0;
      rm_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= qv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= qside.status;
      rp_q <= rp_d;
      rm_q <= rm_d;
    end
  end

  assign root_o.valid       = out_v_q;
  assign root_o.root_status = st_q;
  assign root_o.root_plus   = rp_q;
  assign root_o.root_minus  = rm_q;

  `QRR_ASSERT_IMPL(a_stall_blocks_input, out_v_q && !root_o.ready, !coef_i.ready, "input taken while output stalled")
  `QRR_ASSERT_IMPL(a_no_root_zero, out_v_q && (st_q == StNone || st_q == StZeroA), rp_q == '0 && rm_q == '0, "roots nonzero without real roots")
  `QRR_ASSERT_IMPL(a_repeat_equal, out_v_q && st_q == StRepeat, rp_q == rm_q, "repeated root differs")
  `QRR_ASSERT_NEXT(a_stall_holds, out_v_q && !root_o.ready, out_v_q && $stable(rp_q) && $stable(st_q), "stalled result changed")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives coefficient requests into the quadratic root solver with random
// gaps and output stalls, predicts status and rounded roots exactly, and
// compares every result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import qrr_pkg::*;

  typedef struct {
    logic [1:0]         status;
    logic signed [32:0] plus;
    logic signed [32:0] minus;
  } roots_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    bit                 known;
    status_e            status;
    logic signed [32:0] plus;
    logic signed [32:0] minus;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  qrr_in_if  coef_if ();
  qrr_out_if root_if ();

  roots_t pending_roots[$];
  int     errors = 0;

  quadratic_real_roots u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_if.sink),
    .root_o (root_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Integer square root of a nonnegative value below 2^128.
  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (128'(t) * 128'(t) <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint fdiv(longint n, longint m);
    longint q;
    q = n / m;
    if ((n % m) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic logic signed [32:0] clip_root(longint v);
    if (v > 64'sd4294967295) v = 64'sd4294967295;
    if (v < -64'sd4294967296) v = -64'sd4294967296;
    return v[32:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] qa, logic signed [15:0] qb,
                                         logic signed [15:0] qc);
    roots_t      r;
    longint      a;
    longint      b;
    longint      c;
    longint      d;
    longint      x;
    longint      dv;
    longint      zp;
    longint      zm;
    logic [127:0] d4;
    logic [63:0] s;
    logic [63:0] sc;
    a = longint'(qa);
    b = longint'(qb);
    c = longint'(qc);
    r.plus = '0;
    r.minus = '0;
    if (a == 0) begin
      r.status = StZeroA;
      return r;
    end
    d = b * b - 4 * a * c;
    if (d < 0) begin
      r.status = StNone;
      return r;
    end
    r.status = (d == 0) ? StRepeat : StTwo;
    d4 = 128'(d) << (2 * FracB + 2);
    s = isqrt(d4);
    sc = s + ((128'(s) * 128'(s) != d4) ? 64'd1 : 64'd0);
    x = -2 * b * (64'sd1 <<< FracB) + 2 * a;
    if (a > 0) begin
      dv = 4 * a;
      zp = x + longint'(s);
      zm = x - longint'(sc);
    end else begin
      dv = -4 * a;
      zp = -x - longint'(sc);
      zm = -x + longint'(s);
    end
    r.plus = clip_root(fdiv(zp, dv));
    r.minus = clip_root(fdiv(zm, dv));
    return r;
  endfunction

  // Valid stays high between back-to-back requests and drops only for a gap.
  task automatic send_request(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      coef_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    coef_if.valid <= 1'b1;
    coef_if.coef_quad <= a;
    coef_if.coef_lin <= b;
    coef_if.coef_const <= c;
    do @(posedge clk_i); while (!coef_if.ready);
    pending_roots.insert(pending_roots.size(), solve_roots(a, b, c));
  endtask

  // Checker side: random stalls on the result channel.
  initial begin
    int     stall;
    roots_t want;
    root_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        root_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      root_if.ready <= 1'b1;
      do @(posedge clk_i); while (!root_if.valid);
      if (pending_roots.size() == 0) begin
        $display("%0t: result with no request pending: %0d %0d %0d", $time,
                 root_if.root_status, root_if.root_plus, root_if.root_minus);
        errors++;
      end else begin
        want = pending_roots.pop_front();
        if (root_if.root_status !== want.status) begin
          $display("%0t: root_status expected %0d actual %0d", $time,
                   want.status, root_if.root_status);
          errors++;
        end
        if (root_if.root_plus !== want.plus) begin
          $display("%0t: root_plus expected %0d actual %0d", $time,
                   want.plus, root_if.root_plus);
          errors++;
        end
        if (root_if.root_minus !== want.minus) begin
          $display("%0t: root_minus expected %0d actual %0d", $time,
                   want.minus, root_if.root_minus);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t        rows[$];
    roots_t      got;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    int          mode;
    int          r;
    int          s;
    coef_if.valid = 1'b0;
    coef_if.coef_quad = '0;
    coef_if.coef_lin = '0;
    coef_if.coef_const = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; status and roots are checked where known is set.
    rows = '{
      '{16'sd0, 16'sd5, 16'sd3, 1'b1, StZeroA, 33'sd0, 33'sd0},
      '{16'sd0, -16'sd32768, -16'sd32768, 1'b1, StZeroA, 33'sd0, 33'sd0},
      '{16'sd1, 16'sd0, 16'sd1, 1'b1, StNone, 33'sd0, 33'sd0},
      '{16'sd32767, 16'sd0, 16'sd32767, 1'b1, StNone, 33'sd0, 33'sd0},
      '{16'sd1, -16'sd2, 16'sd1, 1'b1, StRepeat, 33'sd65536, 33'sd65536},
      '{16'sd1, 16'sd0, -16'sd1, 1'b1, StTwo, 33'sd65536, -33'sd65536},
      '{16'sd1, 16'sd0, 16'sd0, 1'b1, StRepeat, 33'sd0, 33'sd0},
      '{-16'sd1, 16'sd0, 16'sd1, 0, StTwo, 0, 0},
      '{16'sd1, -16'sd32768, -16'sd32768, 0, StTwo, 0, 0},
      '{16'sd1, 16'sd32767, 16'sd0, 0, StTwo, 0, 0},
      '{-16'sd32768, 16'sd32767, 16'sd32767, 0, StTwo, 0, 0},
      '{-16'sd32768, -16'sd32768, 16'sd32767, 0, StTwo, 0, 0},
      '{16'sd32767, -16'sd32768, -16'sd32768, 0, StTwo, 0, 0},
      '{16'sd3, 16'sd1, 16'sd0, 0, StTwo, 0, 0},
      '{-16'sd3, 16'sd7, 16'sd2, 0, StTwo, 0, 0},
      '{16'sd4, 16'sd1, -16'sd1, 0, StTwo, 0, 0},
      '{-16'sd1, -16'sd1, 16'sd0, 0, StTwo, 0, 0},
      '{-16'sd1, 16'sd1, 16'sd32767, 0, StTwo, 0, 0},
      '{-16'sd32768, 16'sd0, -16'sd32768, 1'b1, StNone, 33'sd0, 33'sd0}
    };
    foreach (rows[i]) begin
      if (rows[i].known) begin
        got = solve_roots(rows[i].a, rows[i].b, rows[i].c);
        if (got.status !== rows[i].status || got.plus !== rows[i].plus ||
            got.minus !== rows[i].minus) begin
          $display("%0t: table row %0d expected %0d %0d %0d predicted %0d %0d %0d",
                   $time, i, rows[i].status, rows[i].plus, rows[i].minus,
                   got.status, got.plus, got.minus);
          errors++;
        end
      end
      send_request(rows[i].a, rows[i].b, rows[i].c);
    end

    // Let the pipeline drain completely once before the random part.
    coef_if.valid <= 1'b0;
    wait (pending_roots.size() == 0);

    for (int n = 0; n < 850; n++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      mode = $urandom_range(0, 9);
      if (mode == 0) a = '0;
      else if (mode == 1) begin
        // Integer roots: a*(x-r)*(x-s) with small a, r, s, sometimes with r equal to s.
        a = 16'($urandom_range(1, 20));
        if ($urandom_range(0, 1) == 1) a = -a;
        r = int'($urandom_range(0, 60)) - 30;
        s = ($urandom_range(0, 2) == 0) ? r : int'($urandom_range(0, 60)) - 30;
        b = 16'(-$signed(a) * (r + s));
        c = 16'($signed(a) * r * s);
      end else if (mode == 2) begin
        a = 16'(int'($urandom_range(0, 15)) - 8);
        b = 16'(int'($urandom_range(0, 31)) - 16);
        c = 16'(int'($urandom_range(0, 31)) - 16);
      end
      send_request(a, b, c);
    end

    coef_if.valid <= 1'b0;
    wait (pending_roots.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/qrr_pkg.sv
rtl/qrr_if.sv
rtl/qrr_disc.sv
rtl/qrr_sqrt.sv
rtl/qrr_div.sv
rtl/quadratic_real_roots.sv
test/testbench.sv
